// ===== hdl/intake_mechanism_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef INTAKE_MECHANISM_SEQUENCER_DEFINES_SVH
`define INTAKE_MECHANISM_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define IMS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define IMS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define IMS_ASSERT(name, clk, rst_n, prop)
`define IMS_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/ims_pkg.sv =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer package
// Shared types, codes and constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

  typedef enum logic [2:0] {
    MODE_DISABLE = 3'd0,
    MODE_RESET   = 3'd1,
    MODE_INTAKE  = 3'd2,
    MODE_STORE   = 3'd3,
    MODE_DEPOSIT = 3'd4,
    MODE_DOWN    = 3'd5,
    MODE_MAG_OUT = 3'd6,
    MODE_MAG_IN  = 3'd7
  } mode_e;

  localparam logic [3:0] CMD_DISABLE      = 4'd1;
  localparam logic [3:0] CMD_DEPOSIT      = 4'd5;
  localparam logic [3:0] CMD_SWITCH_LEFT  = 4'd9;
  localparam logic [3:0] CMD_SWITCH_RIGHT = 4'd10;

  localparam logic [1:0] CFG_ARM_UP_LEVEL       = 2'd0;
  localparam logic [1:0] CFG_WHEEL_INTAKE_LEVEL = 2'd1;
  localparam logic [1:0] CFG_STORE_WAIT         = 2'd2;
  localparam logic [1:0] CFG_DEPOSIT_WAIT       = 2'd3;

  localparam logic [6:0] ARM_UP_RESET       = 7'd80;
  localparam logic [6:0] WHEEL_INTAKE_RESET = 7'd60;
  localparam logic [7:0] STORE_WAIT_RESET   = 8'd2;
  localparam logic [7:0] DEPOSIT_WAIT_RESET = 8'd4;

  localparam logic [6:0] LVL_MAX = 7'd100;
  localparam logic signed [7:0] LVL_ZERO      = 8'sd0;
  localparam logic signed [7:0] LVL_SLOW      = 8'sd40;
  localparam logic signed [7:0] LVL_HALF      = 8'sd50;
  localparam logic signed [7:0] LVL_FAST_DOWN = 8'sd70;
  localparam logic [7:0] SECONDS_MAX = 8'd255;

  typedef struct packed {
    logic [6:0] arm_up_level;
    logic [6:0] wheel_intake_level;
    logic [7:0] store_wait;
    logic [7:0] deposit_wait;
  } cfg_t;

  typedef struct packed {
    logic [3:0] command;
    logic       arm_up_switch;
    logic       arm_down_switch;
    logic       wheel_fwd_switch;
    logic       wheel_rev_switch;
    logic       touch_fwd_switch;
    logic       touch_rev_switch;
    logic       second_pulse;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    logic              side;
    logic [7:0]        elapsed;
    logic signed [7:0] arm;
    logic signed [7:0] wheel;
    logic signed [7:0] right_conv;
    logic signed [7:0] left_conv;
  } state_t;

  function automatic logic signed [7:0] capped(input logic [6:0] v);
    return (v > LVL_MAX) ? $signed({1'b0, LVL_MAX}) : $signed({1'b0, v});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ims_if.sv =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer channels
// Valid/ready channels for ticks, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface ims_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic       arm_up_switch;
  logic       arm_down_switch;
  logic       wheel_fwd_switch;
  logic       wheel_rev_switch;
  logic       touch_fwd_switch;
  logic       touch_rev_switch;
  logic       second_pulse;

  modport source (
    output valid, command, arm_up_switch, arm_down_switch, wheel_fwd_switch,
           wheel_rev_switch, touch_fwd_switch, touch_rev_switch, second_pulse,
    input  ready
  );
  modport sink (
    input  valid, command, arm_up_switch, arm_down_switch, wheel_fwd_switch,
           wheel_rev_switch, touch_fwd_switch, touch_rev_switch, second_pulse,
    output ready
  );
endinterface

interface ims_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] arm_drive;
  logic signed [7:0] wheel_drive;
  logic signed [7:0] right_conveyor_drive;
  logic signed [7:0] left_conveyor_drive;
  logic [2:0]        mode_now;
  logic              side_now;
  logic              docked;

  modport source (
    output valid, arm_drive, wheel_drive, right_conveyor_drive,
           left_conveyor_drive, mode_now, side_now, docked,
    input  ready
  );
  modport sink (
    input  valid, arm_drive, wheel_drive, right_conveyor_drive,
           left_conveyor_drive, mode_now, side_now, docked,
    output ready
  );
endinterface

interface ims_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/intake_mechanism_sequencer.sv =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer
// Mode sequencer for an intake arm, intake wheel and two magazine conveyors.
// ---------------------------------------------------------------------------
// One transfer on in_i is one control tick; each tick yields exactly one
// transfer on out_o carrying the mode, side, docked flag and the four drive
// levels after that tick. A tick is taken into an input register, evaluated
// against the sequencer state and latched into the result register, which
// also holds that state. The block accepts one tick per cycle while out_o is
// not stalled; a result is registered once its tick leaves the input register
// and holds while out_o is stalled. The user must write registers on cfg_i
// only while idle; the block itself does not enforce it.
`default_nettype none
`include "intake_mechanism_sequencer_defines.svh"

module intake_mechanism_sequencer (
  input  wire      clk_i,
  input  wire      rst_ni,
  ims_in_if.sink   in_i,
  ims_cfg_if.sink  cfg_i,
  ims_out_if.source out_o
);

  ims_pkg::cfg_t   cfg;
  ims_pkg::item_t  item_q;
  ims_pkg::state_t state_q;
  ims_pkg::state_t state_d;
  logic            item_vld_q;
  logic            out_vld_q;
  logic            docked_q;
  logic            docked_d;
  logic            in_xfer;
  logic            advance;

  ims_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ims_rules u_rules (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .docked_o (docked_d)
  );

  assign advance    = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q         <= 1'b0;
      out_vld_q          <= 1'b0;
      docked_q           <= 1'b0;
      state_q.mode       <= ims_pkg::MODE_DISABLE;
      state_q.side       <= 1'b0;
      state_q.elapsed    <= 8'd0;
      state_q.arm        <= ims_pkg::LVL_ZERO;
      state_q.wheel      <= ims_pkg::LVL_ZERO;
      state_q.right_conv <= ims_pkg::LVL_ZERO;
      state_q.left_conv  <= ims_pkg::LVL_ZERO;
    end else begin
      if (in_xfer) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        docked_q  <= docked_d;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.command          <= in_i.command;
      item_q.arm_up_switch    <= in_i.arm_up_switch;
      item_q.arm_down_switch  <= in_i.arm_down_switch;
      item_q.wheel_fwd_switch <= in_i.wheel_fwd_switch;
      item_q.wheel_rev_switch <= in_i.wheel_rev_switch;
      item_q.touch_fwd_switch <= in_i.touch_fwd_switch;
      item_q.touch_rev_switch <= in_i.touch_rev_switch;
      item_q.second_pulse     <= in_i.second_pulse;
    end
  end

  assign out_o.valid                = out_vld_q;
  assign out_o.arm_drive            = state_q.arm;
  assign out_o.wheel_drive          = state_q.wheel;
  assign out_o.right_conveyor_drive = state_q.right_conv;
  assign out_o.left_conveyor_drive  = state_q.left_conv;
  assign out_o.mode_now             = state_q.mode;
  assign out_o.side_now             = state_q.side;
  assign out_o.docked               = docked_q;

  `IMS_ASSERT(a_docked_disables, clk_i, rst_ni,
    out_vld_q && docked_q |-> state_q.mode == ims_pkg::MODE_DISABLE)
  `IMS_ASSERT(a_stall_blocks_intake, clk_i, rst_ni,
    item_vld_q && out_vld_q && !out_o.ready |-> !in_i.ready)
  `IMS_ASSERT_NEXT(a_xfer_fills_stage, clk_i, rst_ni, in_xfer, item_vld_q)
  `IMS_ASSERT(a_arm_in_range, clk_i, rst_ni,
    out_vld_q |-> state_q.arm >= -8'sd100 && state_q.arm <= 8'sd100)

endmodule

`default_nettype wire

// ===== hdl/ims_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer configuration registers
// Drive levels and wait times, written through the register channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ims_cfg_regs (
  input  wire           clk_i,
  input  wire           rst_ni,
  ims_cfg_if.sink       cfg_i,
  output ims_pkg::cfg_t cfg_o
);

  ims_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_up_level       <= ims_pkg::ARM_UP_RESET;
      cfg_q.wheel_intake_level <= ims_pkg::WHEEL_INTAKE_RESET;
      cfg_q.store_wait         <= ims_pkg::STORE_WAIT_RESET;
      cfg_q.deposit_wait       <= ims_pkg::DEPOSIT_WAIT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        ims_pkg::CFG_ARM_UP_LEVEL:       cfg_q.arm_up_level       <= cfg_i.wdata[6:0];
        ims_pkg::CFG_WHEEL_INTAKE_LEVEL: cfg_q.wheel_intake_level <= cfg_i.wdata[6:0];
        ims_pkg::CFG_STORE_WAIT:         cfg_q.store_wait         <= cfg_i.wdata;
        ims_pkg::CFG_DEPOSIT_WAIT:       cfg_q.deposit_wait       <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ims_rules.sv =====
// ---------------------------------------------------------------------------
// Intake mechanism sequencer tick rules
// Next mode, side, seconds count and drive levels for one tick.
// ---------------------------------------------------------------------------
`default_nettype none

module ims_rules (
  input  ims_pkg::item_t  item_i,
  input  ims_pkg::state_t state_i,
  input  ims_pkg::cfg_t   cfg_i,
  output ims_pkg::state_t state_o,
  output logic            docked_o
);

  logic              docked;
  logic              up;
  logic              down;
  logic              side_sw;
  logic              late;
  logic signed [7:0] slow_s;
  logic signed [7:0] arm_lvl;
  logic signed [7:0] intake_lvl;
  ims_pkg::state_t   st;

  assign docked   = item_i.touch_fwd_switch | item_i.touch_rev_switch;
  assign docked_o = docked;
  assign up       = item_i.arm_up_switch;
  assign down     = item_i.arm_down_switch;
  assign side_sw  = state_i.side ? item_i.wheel_rev_switch : item_i.wheel_fwd_switch;
  assign slow_s   = state_i.side ? -ims_pkg::LVL_SLOW : ims_pkg::LVL_SLOW;
  assign arm_lvl  = ims_pkg::capped(cfg_i.arm_up_level);
  assign intake_lvl = state_i.side ? ims_pkg::capped(cfg_i.wheel_intake_level)
                                   : -ims_pkg::capped(cfg_i.wheel_intake_level);

  always_comb begin
    st   = state_i;
    late = 1'b0;
    if (item_i.second_pulse && (st.elapsed != ims_pkg::SECONDS_MAX)) begin
      st.elapsed = st.elapsed + 8'd1;
    end
    if (docked) begin
      st.mode = ims_pkg::MODE_DISABLE;
    end

    case (st.mode)
      ims_pkg::MODE_DISABLE: begin
        st.arm        = ims_pkg::LVL_ZERO;
        st.wheel      = ims_pkg::LVL_ZERO;
        st.right_conv = ims_pkg::LVL_ZERO;
        st.left_conv  = ims_pkg::LVL_ZERO;
      end
      ims_pkg::MODE_RESET: begin
        st.wheel      = ims_pkg::LVL_ZERO;
        st.right_conv = ims_pkg::LVL_ZERO;
        st.left_conv  = ims_pkg::LVL_ZERO;
        st.arm        = up ? arm_lvl : ims_pkg::LVL_ZERO;
      end
      ims_pkg::MODE_INTAKE: begin
        st.right_conv = ims_pkg::LVL_ZERO;
        st.left_conv  = ims_pkg::LVL_ZERO;
        st.wheel      = side_sw ? ims_pkg::LVL_ZERO : intake_lvl;
        st.arm        = down ? -ims_pkg::LVL_HALF : ims_pkg::LVL_ZERO;
      end
      ims_pkg::MODE_STORE: begin
        if (!up) begin
          st.arm   = ims_pkg::LVL_ZERO;
          st.wheel = slow_s;
          if (!state_i.side) st.right_conv = -ims_pkg::LVL_SLOW;
          else               st.left_conv  = ims_pkg::LVL_SLOW;
          if (st.elapsed > cfg_i.store_wait) st.mode = ims_pkg::MODE_RESET;
        end else begin
          st.arm        = arm_lvl;
          st.wheel      = ims_pkg::LVL_ZERO;
          st.right_conv = ims_pkg::LVL_ZERO;
          st.left_conv  = ims_pkg::LVL_ZERO;
          st.elapsed    = 8'd0;
        end
      end
      ims_pkg::MODE_DEPOSIT: begin
        if (!up) st.elapsed = 8'd0;
        if (!down) begin
          st.arm        = ims_pkg::LVL_ZERO;
          st.wheel      = slow_s;
          st.right_conv = ims_pkg::LVL_ZERO;
          st.left_conv  = ims_pkg::LVL_ZERO;
          st.elapsed    = 8'd0;
        end else begin
          late = st.elapsed > cfg_i.deposit_wait;
          if (side_sw) begin
            st.wheel      = late ? slow_s : ims_pkg::LVL_ZERO;
            st.right_conv = ims_pkg::LVL_ZERO;
            st.left_conv  = ims_pkg::LVL_ZERO;
            st.arm        = -ims_pkg::LVL_HALF;
          end else begin
            st.wheel = late ? slow_s : -slow_s;
            if (!state_i.side) begin
              if (!up) st.right_conv = ims_pkg::LVL_SLOW;
              st.left_conv = ims_pkg::LVL_ZERO;
            end else begin
              if (!up) st.left_conv = -ims_pkg::LVL_SLOW;
              st.right_conv = ims_pkg::LVL_ZERO;
            end
            st.arm = ims_pkg::LVL_ZERO;
          end
        end
      end
      ims_pkg::MODE_DOWN: begin
        st.wheel      = ims_pkg::LVL_ZERO;
        st.right_conv = ims_pkg::LVL_ZERO;
        st.left_conv  = ims_pkg::LVL_ZERO;
        st.arm        = down ? -ims_pkg::LVL_FAST_DOWN : ims_pkg::LVL_ZERO;
      end
      ims_pkg::MODE_MAG_OUT: begin
        st.wheel      = ims_pkg::LVL_ZERO;
        st.arm        = ims_pkg::LVL_ZERO;
        st.right_conv = ims_pkg::LVL_SLOW;
        st.left_conv  = -ims_pkg::LVL_SLOW;
      end
      default: begin
        st.wheel      = ims_pkg::LVL_ZERO;
        st.arm        = ims_pkg::LVL_ZERO;
        st.right_conv = -ims_pkg::LVL_SLOW;
        st.left_conv  = ims_pkg::LVL_SLOW;
      end
    endcase

    if (!docked && (item_i.command >= ims_pkg::CMD_DISABLE)
        && (item_i.command <= ims_pkg::CMD_SWITCH_RIGHT)) begin
      if (item_i.command == ims_pkg::CMD_DEPOSIT) st.elapsed = 8'd0;
      if (item_i.command == ims_pkg::CMD_SWITCH_LEFT) begin
        st.side = 1'b1;
      end else if (item_i.command == ims_pkg::CMD_SWITCH_RIGHT) begin
        st.side = 1'b0;
      end else begin
        st.mode = ims_pkg::mode_e'(3'(item_i.command - ims_pkg::CMD_DISABLE));
      end
    end

    state_o = st;
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intake mechanism sequencer testbench
// Drives control ticks and register writes into the sequencer, predicts the
// drive levels, mode, side and docked flag of every tick, and compares each
// result transfer field by field in order of arrival. A directed pass over
// every mode and command comes first, then random runs of mode commands
// with held switch readings under several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import ims_pkg::*;

  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_RESET   = 4'd2;
  localparam logic [3:0] CMD_INTAKE  = 4'd3;
  localparam logic [3:0] CMD_STORE   = 4'd4;
  localparam logic [3:0] CMD_DOWN    = 4'd6;
  localparam logic [3:0] CMD_MAG_OUT = 4'd7;
  localparam logic [3:0] CMD_MAG_IN  = 4'd8;
  localparam logic [3:0] CMD_SPARE   = 4'd15;

  localparam logic [6:0] SW_UP    = 7'b1000000;
  localparam logic [6:0] SW_DOWN  = 7'b0100000;
  localparam logic [6:0] SW_WFWD  = 7'b0010000;
  localparam logic [6:0] SW_WREV  = 7'b0001000;
  localparam logic [6:0] SW_TFWD  = 7'b0000100;
  localparam logic [6:0] SW_TREV  = 7'b0000010;
  localparam logic [6:0] SW_PULSE = 7'b0000001;

  typedef struct packed {
    logic signed [7:0] arm;
    logic signed [7:0] wheel;
    logic signed [7:0] right_conv;
    logic signed [7:0] left_conv;
    logic [2:0]        mode;
    logic              side;
    logic              docked;
  } drive_t;

  class drive_scoreboard;
    logic [6:0]        arm_up_lvl;
    logic [6:0]        wheel_in_lvl;
    logic [7:0]        store_secs;
    logic [7:0]        deposit_secs;
    mode_e             mode;
    logic              side;
    logic [7:0]        seconds;
    logic signed [7:0] arm;
    logic signed [7:0] wheel;
    logic signed [7:0] rconv;
    logic signed [7:0] lconv;
    drive_t            drives_q[$];
    int unsigned       fails;

    function new();
      arm_up_lvl   = ARM_UP_RESET;
      wheel_in_lvl = WHEEL_INTAKE_RESET;
      store_secs   = STORE_WAIT_RESET;
      deposit_secs = DEPOSIT_WAIT_RESET;
      mode    = MODE_DISABLE;
      side    = 1'b0;
      seconds = '0;
      arm     = '0;
      wheel   = '0;
      rconv   = '0;
      lconv   = '0;
      fails   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_ARM_UP_LEVEL:       arm_up_lvl = data[6:0];
        CFG_WHEEL_INTAKE_LEVEL: wheel_in_lvl = data[6:0];
        CFG_STORE_WAIT:         store_secs = data;
        default:                deposit_secs = data;
      endcase
    endfunction

    function int level_of(logic [6:0] v);
      return (v > LVL_MAX) ? int'(LVL_MAX) : int'(v);
    endfunction

    function int pending();
      return drives_q.size();
    endfunction

    function void note_tick(item_t it);
      int     s;
      logic   up, down, side_sw, dock, late;
      drive_t d;
      s       = side ? -1 : 1;
      up      = it.arm_up_switch;
      down    = it.arm_down_switch;
      side_sw = side ? it.wheel_rev_switch : it.wheel_fwd_switch;
      dock    = it.touch_fwd_switch | it.touch_rev_switch;
      if (it.second_pulse && seconds != SECONDS_MAX) seconds++;
      if (dock) mode = MODE_DISABLE;
      case (mode)
        MODE_DISABLE: begin
          arm = 0; wheel = 0; rconv = 0; lconv = 0;
        end
        MODE_RESET: begin
          wheel = 0; rconv = 0; lconv = 0;
          arm = up ? level_of(arm_up_lvl) : 0;
        end
        MODE_INTAKE: begin
          rconv = 0; lconv = 0;
          wheel = side_sw ? 0 : -level_of(wheel_in_lvl) * s;
          arm = down ? -LVL_HALF : 0;
        end
        MODE_STORE: begin
          if (!up) begin
            arm = 0;
            wheel = LVL_SLOW * s;
            if (!side) rconv = -LVL_SLOW;
            else lconv = LVL_SLOW;
            if (seconds > store_secs) mode = MODE_RESET;
          end else begin
            arm = level_of(arm_up_lvl);
            wheel = 0; rconv = 0; lconv = 0;
            seconds = '0;
          end
        end
        MODE_DEPOSIT: begin
          if (!up) seconds = '0;
          if (!down) begin
            arm = 0;
            wheel = LVL_SLOW * s;
            rconv = 0; lconv = 0;
            seconds = '0;
          end else begin
            late = seconds > deposit_secs;
            if (side_sw) begin
              wheel = late ? LVL_SLOW * s : 0;
              rconv = 0; lconv = 0;
              arm = -LVL_HALF;
            end else begin
              wheel = late ? LVL_SLOW * s : -LVL_SLOW * s;
              if (!side) begin
                if (!up) rconv = LVL_SLOW;
                lconv = 0;
              end else begin
                if (!up) lconv = -LVL_SLOW;
                rconv = 0;
              end
              arm = 0;
            end
          end
        end
        MODE_DOWN: begin
          wheel = 0; rconv = 0; lconv = 0;
          arm = down ? -LVL_FAST_DOWN : 0;
        end
        MODE_MAG_OUT: begin
          wheel = 0; arm = 0; rconv = LVL_SLOW; lconv = -LVL_SLOW;
        end
        default: begin
          wheel = 0; arm = 0; rconv = -LVL_SLOW; lconv = LVL_SLOW;
        end
      endcase
      if (!dock && it.command >= CMD_DISABLE && it.command <= CMD_SWITCH_RIGHT) begin
        if (it.command == CMD_DEPOSIT) seconds = '0;
        if (it.command == CMD_SWITCH_LEFT) side = 1'b1;
        else if (it.command == CMD_SWITCH_RIGHT) side = 1'b0;
        else mode = mode_e'(3'(it.command - CMD_DISABLE));
      end
      d.arm        = arm;
      d.wheel      = wheel;
      d.right_conv = rconv;
      d.left_conv  = lconv;
      d.mode       = mode;
      d.side       = side;
      d.docked     = dock;
      drives_q = {drives_q, d};
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (drives_q.size() == 0) begin
        $error("result transfer with no tick pending");
        fails++;
        return;
      end
      want = drives_q.pop_front();
      if (got.arm !== want.arm) begin
        $error("arm_drive: expected %0d, got %0d", want.arm, got.arm);
        fails++;
      end
      if (got.wheel !== want.wheel) begin
        $error("wheel_drive: expected %0d, got %0d", want.wheel, got.wheel);
        fails++;
      end
      if (got.right_conv !== want.right_conv) begin
        $error("right_conveyor_drive: expected %0d, got %0d", want.right_conv,
               got.right_conv);
        fails++;
      end
      if (got.left_conv !== want.left_conv) begin
        $error("left_conveyor_drive: expected %0d, got %0d", want.left_conv,
               got.left_conv);
        fails++;
      end
      if (got.mode !== want.mode) begin
        $error("mode_now: expected %0d, got %0d", want.mode, got.mode);
        fails++;
      end
      if (got.side !== want.side) begin
        $error("side_now: expected %0d, got %0d", want.side, got.side);
        fails++;
      end
      if (got.docked !== want.docked) begin
        $error("docked: expected %0d, got %0d", want.docked, got.docked);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;
  drive_scoreboard board;

  ims_in_if  in_if();
  ims_out_if out_if();
  ims_cfg_if cfg_if();

  intake_mechanism_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : receiver
    int unsigned cyc;
    int unsigned hold_left;
    cyc = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni && cyc % 2500 == 1200) hold_left = 200;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result(drive_t'({out_if.arm_drive, out_if.wheel_drive,
                                   out_if.right_conveyor_drive,
                                   out_if.left_conveyor_drive, out_if.mode_now,
                                   out_if.side_now, out_if.docked}));
    end
  end

  task automatic offer_tick(item_t it);
    while (!calm && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.command          <= it.command;
    in_if.arm_up_switch    <= it.arm_up_switch;
    in_if.arm_down_switch  <= it.arm_down_switch;
    in_if.wheel_fwd_switch <= it.wheel_fwd_switch;
    in_if.wheel_rev_switch <= it.wheel_rev_switch;
    in_if.touch_fwd_switch <= it.touch_fwd_switch;
    in_if.touch_rev_switch <= it.touch_rev_switch;
    in_if.second_pulse     <= it.second_pulse;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_tick(it);
  endtask

  task automatic send_tick(logic [3:0] cmd, logic [6:0] sw);
    offer_tick(item_t'({cmd, sw}));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic set_config(logic [7:0] arm_w, logic [7:0] wheel_w,
                            logic [7:0] store_w, logic [7:0] deposit_w);
    drain();
    write_reg(CFG_ARM_UP_LEVEL, arm_w);
    write_reg(CFG_WHEEL_INTAKE_LEVEL, wheel_w);
    write_reg(CFG_STORE_WAIT, store_w);
    write_reg(CFG_DEPOSIT_WAIT, deposit_w);
    cfg_if.valid <= 1'b0;
  endtask

  // Mode command followed by a run of ticks with held switch readings, mixed with single fully random ticks.
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned run_len;
    logic [3:0]  held;
    item_t       it;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 20) begin
        it = item_t'(11'($urandom));
        offer_tick(it);
        sent++;
      end else begin
        held = 4'($urandom);
        it.command = 4'($urandom_range(CMD_SWITCH_RIGHT, CMD_DISABLE));
        run_len = $urandom_range(30, 3);
        for (int i = 0; i <= run_len && sent < n; i++) begin
          if (i != 0) begin
            it.command = ($urandom_range(99) < 6) ?
                         4'($urandom_range(CMD_SWITCH_RIGHT, CMD_SWITCH_LEFT)) : CMD_NONE;
          end
          for (int b = 0; b < 4; b++) begin
            if ($urandom_range(99) < 8) held[b] = ~held[b];
          end
          {it.arm_up_switch, it.arm_down_switch,
           it.wheel_fwd_switch, it.wheel_rev_switch} = held;
          it.touch_fwd_switch = ($urandom_range(99) < 2);
          it.touch_rev_switch = ($urandom_range(99) < 2);
          it.second_pulse     = ($urandom_range(99) < 60);
          offer_tick(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    board = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    in_if.valid            <= 1'b0;
    in_if.command          <= CMD_NONE;
    in_if.arm_up_switch    <= 1'b0;
    in_if.arm_down_switch  <= 1'b0;
    in_if.wheel_fwd_switch <= 1'b0;
    in_if.wheel_rev_switch <= 1'b0;
    in_if.touch_fwd_switch <= 1'b0;
    in_if.touch_rev_switch <= 1'b0;
    in_if.second_pulse     <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= CFG_ARM_UP_LEVEL;
    cfg_if.wdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(CMD_NONE, '0);
    send_tick(CMD_RESET, SW_UP);
    send_tick(CMD_NONE, SW_UP | SW_PULSE);
    send_tick(CMD_INTAKE, SW_DOWN);
    send_tick(CMD_NONE, SW_DOWN | SW_WFWD);
    send_tick(CMD_SWITCH_LEFT, SW_WFWD);
    send_tick(CMD_NONE, SW_DOWN | SW_WREV);
    send_tick(CMD_NONE, '0);
    send_tick(CMD_STORE, SW_PULSE);
    repeat (3) send_tick(CMD_NONE, SW_PULSE);
    send_tick(CMD_STORE, SW_UP);
    send_tick(CMD_NONE, SW_UP);
    send_tick(CMD_DEPOSIT, SW_PULSE);
    send_tick(CMD_NONE, SW_DOWN | SW_WREV | SW_PULSE);
    send_tick(CMD_NONE, SW_DOWN | SW_UP | SW_PULSE);
    send_tick(CMD_SWITCH_RIGHT, SW_DOWN | SW_UP);
    send_tick(CMD_DOWN, SW_DOWN);
    send_tick(CMD_MAG_OUT, '0);
    send_tick(CMD_MAG_IN, '0);
    send_tick(CMD_SPARE, SW_PULSE);
    send_tick(CMD_INTAKE, SW_TREV);
    send_tick(CMD_SWITCH_LEFT, SW_TFWD | SW_TREV);
    send_tick(CMD_DISABLE, SW_UP | SW_DOWN | SW_WFWD | SW_WREV | SW_PULSE);
    send_tick(CMD_SPARE, '1);

    set_config(8'hFF, 8'hFF, 8'd0, 8'd0);
    run_random(300);

    // Saturate the seconds count so a full wait never runs out.
    set_config(8'd0, 8'd0, 8'd255, 8'd255);
    send_tick(CMD_MAG_OUT, SW_PULSE);
    repeat (270) send_tick(CMD_NONE, SW_PULSE);
    send_tick(CMD_STORE, SW_PULSE);
    repeat (5) send_tick(CMD_NONE, SW_PULSE | SW_DOWN);
    run_random(150);

    calm = 1'b1;
    set_config(8'd100, 8'd100, 8'd1, 8'd2);
    run_random(250);
    calm = 1'b0;

    repeat (3) begin
      set_config(8'($urandom_range(127)), 8'($urandom_range(127)),
                 8'($urandom_range(6)), 8'($urandom_range(8)));
      run_random(250);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
